### hw/rtl/qos_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Queue-of-stacks store package
// Field widths, beat layouts, register indexes and controller commands.
// ----------------------------------------------------------------------------
package qos_pkg;

  localparam int CFG_W     = 4;
  localparam int CFG_IDX_W = 1;

  localparam int DEST_W    = 16;
  localparam int VALUE_W   = 32;
  localparam int PAYLOAD_W = DEST_W + VALUE_W;

  localparam int IN_DATA_W = 48;
  localparam int IN_USER_W = 1;

  localparam int OUT_FIELDS_W = 2 + DEST_W + VALUE_W + 2;
  localparam int OUT_DATA_W   = 56;
  localparam int OUT_PAD_W    = OUT_DATA_W - OUT_FIELDS_W;

  localparam int OUT_ACC_BIT   = 0;
  localparam int OUT_VALID_BIT = 1;
  localparam int OUT_EMPTY_BIT = 2 + DEST_W + VALUE_W;
  localparam int OUT_FULL_BIT  = OUT_EMPTY_BIT + 1;

  localparam logic [CFG_IDX_W-1:0] REG_NUM_STACKS   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_STACK_HEIGHT = 1'b1;
  localparam logic [CFG_W-1:0]     REG_RESET_VALUE  = 4'd8;

  localparam logic CMD_STORE = 1'b0;
  localparam logic CMD_SHIP  = 1'b1;

  typedef struct packed {
    logic load_in;
    logic store_exec;
    logic ship_fill;
    logic ship_out;
  } qos_cmd_t;

endpackage

### hw/rtl/qos_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Queue-of-stacks store controller
// Sequences one command at a time and issues datapath commands.
// ----------------------------------------------------------------------------
module qos_ctrl import qos_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  logic     in_cmd,
  output logic     in_ready,
  input  logic     out_free,
  output qos_cmd_t cmd
);

  typedef enum logic [1:0] {
    IDLE,
    STORE_EXEC,
    SHIP_FILL,
    SHIP_OUT
  } state_t;

  state_t state;

  always_comb begin
    cmd.load_in    = in_valid && in_ready;
    cmd.store_exec = (state == STORE_EXEC) && out_free;
    cmd.ship_fill  = (state == SHIP_FILL);
    cmd.ship_out   = (state == SHIP_OUT) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      in_ready <= 1'b1;
    end else begin
      unique case (state)
        IDLE: begin
          if (in_valid && in_ready) begin
            in_ready <= 1'b0;
            state    <= (in_cmd == CMD_SHIP) ? SHIP_FILL : STORE_EXEC;
          end
        end
        STORE_EXEC: begin
          if (out_free) begin
            in_ready <= 1'b1;
            state    <= IDLE;
          end
        end
        SHIP_FILL: begin
          state <= SHIP_OUT;
        end
        SHIP_OUT: begin
          if (out_free) begin
            in_ready <= 1'b1;
            state    <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

### hw/rtl/qos_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Queue-of-stacks store datapath
// Ring pointers, fill and payload memories, limits and the result register.
// ----------------------------------------------------------------------------
module qos_datapath import qos_pkg::*; #(
  parameter int MAX_STACKS = 8,
  parameter int MAX_HEIGHT = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  qos_cmd_t              cmd,
  output logic                  out_free,
  input  logic [IN_DATA_W-1:0]  in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [OUT_DATA_W-1:0] out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_data
);

  localparam int IDX_W  = (MAX_STACKS > 1) ? $clog2(MAX_STACKS) : 1;
  localparam int CNT_W  = $clog2(MAX_STACKS + 1);
  localparam int SUM_W  = CNT_W + 1;
  localparam int FILL_W = $clog2(MAX_HEIGHT + 1);
  localparam int SLOTS  = MAX_STACKS * MAX_HEIGHT;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int NCMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int HCMP_W = (FILL_W > CFG_W) ? FILL_W : CFG_W;

  logic [CFG_W-1:0]     num_stacks;
  logic [CFG_W-1:0]     stack_height;
  logic [IDX_W-1:0]     oldest;
  logic [CNT_W-1:0]     open_count;
  logic [FILL_W-1:0]    newest_fill;
  logic [DEST_W-1:0]    item_dest;
  logic [VALUE_W-1:0]   item_value;
  logic                 ship_hit;

  logic [FILL_W-1:0]    fill_mem [MAX_STACKS];
  logic [FILL_W-1:0]    fill_rd;
  logic [PAYLOAD_W-1:0] payload_mem [SLOTS];
  logic [PAYLOAD_W-1:0] payload_rd;

  logic                 res_accepted;
  logic                 res_valid;
  logic [DEST_W-1:0]    res_dest;
  logic [VALUE_W-1:0]   res_value;
  logic                 res_empty;
  logic                 res_full;

  logic [NCMP_W-1:0]    n_lim;
  logic [HCMP_W-1:0]    h_lim;
  logic [SUM_W-1:0]     oldest_ext;
  logic [SUM_W-1:0]     count_ext;
  logic [IDX_W-1:0]     tail_idx;
  logic [IDX_W-1:0]     newest_idx;
  logic [IDX_W-1:0]     oldest_inc;
  logic                 open_new;
  logic                 store_ok;
  logic [IDX_W-1:0]     top_idx;
  logic [FILL_W-1:0]    top_fill;
  logic [FILL_W-1:0]    top_fill_inc;
  logic [SLOT_W-1:0]    store_slot;
  logic [CNT_W-1:0]     count_store_next;
  logic                 ship_any;
  logic                 ship_hit_c;
  logic [FILL_W-1:0]    fill_dec;
  logic                 ship_close;
  logic [SLOT_W-1:0]    ship_slot;
  logic                 fill_we;
  logic [IDX_W-1:0]     fill_waddr;
  logic [FILL_W-1:0]    fill_wdata;
  logic                 store_write;
  logic [CNT_W-1:0]     flag_count;
  logic [FILL_W-1:0]    flag_fill;
  logic                 flag_empty;
  logic                 flag_full;

  function automatic logic [IDX_W-1:0] ring_wrap(input logic [SUM_W-1:0] s);
    if (s >= SUM_W'(MAX_STACKS)) begin
      return IDX_W'(s - SUM_W'(MAX_STACKS));
    end
    return IDX_W'(s);
  endfunction

  always_comb begin
    if (num_stacks == '0) begin
      n_lim = NCMP_W'(1);
    end else if (NCMP_W'(num_stacks) > NCMP_W'(MAX_STACKS)) begin
      n_lim = NCMP_W'(MAX_STACKS);
    end else begin
      n_lim = NCMP_W'(num_stacks);
    end
    if (stack_height == '0) begin
      h_lim = HCMP_W'(1);
    end else if (HCMP_W'(stack_height) > HCMP_W'(MAX_HEIGHT)) begin
      h_lim = HCMP_W'(MAX_HEIGHT);
    end else begin
      h_lim = HCMP_W'(stack_height);
    end
  end

  assign oldest_ext = SUM_W'(oldest);
  assign count_ext  = SUM_W'(open_count);
  assign tail_idx   = ring_wrap(oldest_ext + count_ext);
  assign newest_idx = ring_wrap(oldest_ext + count_ext - SUM_W'(1));
  assign oldest_inc = ring_wrap(oldest_ext + SUM_W'(1));

  assign open_new = (open_count == '0) ||
                    ((HCMP_W'(newest_fill) >= h_lim) && (NCMP_W'(open_count) < n_lim));
  assign top_fill         = open_new ? '0 : newest_fill;
  assign top_idx          = open_new ? tail_idx : newest_idx;
  assign store_ok         = HCMP_W'(top_fill) < h_lim;
  assign top_fill_inc     = top_fill + FILL_W'(1);
  assign store_slot       = SLOT_W'(top_idx) * SLOT_W'(MAX_HEIGHT) + SLOT_W'(top_fill);
  assign count_store_next = open_count + CNT_W'(open_new);
  assign store_write      = cmd.store_exec && store_ok;

  assign ship_any   = cmd.ship_fill && (open_count != '0);
  assign ship_hit_c = (open_count != '0) && (fill_rd != '0);
  assign fill_dec   = ship_hit_c ? fill_rd - FILL_W'(1) : '0;
  assign ship_close = fill_dec == '0;
  assign ship_slot  = SLOT_W'(oldest) * SLOT_W'(MAX_HEIGHT) + SLOT_W'(fill_dec);

  assign fill_we    = store_write || ship_any;
  assign fill_waddr = cmd.store_exec ? top_idx : oldest;
  assign fill_wdata = cmd.store_exec ? top_fill_inc : fill_dec;

  assign flag_count = store_write ? count_store_next : open_count;
  assign flag_fill  = store_write ? top_fill_inc : newest_fill;
  assign flag_empty = flag_count == '0;
  assign flag_full  = (flag_count != '0) && (NCMP_W'(flag_count) >= n_lim) &&
                      (HCMP_W'(flag_fill) >= h_lim);

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_stacks   <= REG_RESET_VALUE;
      stack_height <= REG_RESET_VALUE;
      oldest       <= '0;
      open_count   <= '0;
      newest_fill  <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_NUM_STACKS:   num_stacks   <= cfg_data;
          REG_STACK_HEIGHT: stack_height <= cfg_data;
          default: ;
        endcase
      end
      if (store_write) begin
        open_count  <= count_store_next;
        newest_fill <= top_fill_inc;
      end
      if (ship_any) begin
        if (open_count == CNT_W'(1)) begin
          newest_fill <= fill_dec;
        end
        if (ship_close) begin
          oldest     <= oldest_inc;
          open_count <= open_count - CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      item_dest  <= in_data[DEST_W-1:0];
      item_value <= in_data[DEST_W +: VALUE_W];
    end
    if (cmd.ship_fill) begin
      ship_hit <= ship_hit_c;
    end
  end

  always_ff @(posedge clk) begin
    if (fill_we) begin
      fill_mem[fill_waddr] <= fill_wdata;
    end
    if (cmd.load_in) begin
      fill_rd <= fill_mem[oldest];
    end
  end

  always_ff @(posedge clk) begin
    if (store_write) begin
      payload_mem[store_slot] <= {item_dest, item_value};
    end
    if (cmd.ship_fill) begin
      payload_rd <= payload_mem[ship_slot];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.store_exec || cmd.ship_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store_exec) begin
      res_accepted <= store_ok;
      res_valid    <= 1'b0;
      res_dest     <= '0;
      res_value    <= '0;
      res_empty    <= flag_empty;
      res_full     <= flag_full;
    end else if (cmd.ship_out) begin
      res_accepted <= 1'b0;
      res_valid    <= ship_hit;
      res_dest     <= ship_hit ? payload_rd[VALUE_W +: DEST_W] : '0;
      res_value    <= ship_hit ? payload_rd[VALUE_W-1:0] : '0;
      res_empty    <= flag_empty;
      res_full     <= flag_full;
    end
  end

  assign out_data = {{OUT_PAD_W{1'b0}}, res_full, res_empty, res_value, res_dest,
                     res_valid, res_accepted};

endmodule

### hw/rtl/queue_of_stacks_store_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Queue-of-stacks store
// A ring of open stacks: stores push onto the newest, ships pop the oldest.
// ----------------------------------------------------------------------------
//  Channel   Direction  Contents
//  s_axis    in         tdata: item_destination, item_value; tuser: command
//  m_axis    out        tdata: result fields and empty and full flags
//  cfg       in         num_stacks (index 0), stack_height (index 1)
//
//  A store is executed in STORE_EXEC; a ship reads the fill memory at its beat
//  and the payload memory in SHIP_FILL, each registered, then ends in SHIP_OUT.
//  Reset is synchronous, clears the controller and ring pointers and sets both
//  limits to 8; the memories are not cleared, as only written entries are used.
//  One command is worked at a time; a result waiting in the output register
//  does not block the next input beat, only the completion of that command.
// ----------------------------------------------------------------------------
module queue_of_stacks_store_top import qos_pkg::*; #(
  parameter int MAX_STACKS = 8,
  parameter int MAX_HEIGHT = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // item_destination [15:0], item_value [47:16]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // command [0]
  input  logic [IN_USER_W-1:0]  s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // store_accepted [0], ship_valid [1], shipped_destination [17:2],
  // shipped_value [49:18], now_empty [50], now_full [51], zero [55:52]
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_data
);

  qos_cmd_t cmd;
  logic     out_free;

  qos_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_cmd   (s_axis_tuser[0]),
    .in_ready (s_axis_tready),
    .out_free (out_free),
    .cmd      (cmd)
  );

  qos_datapath #(
    .MAX_STACKS (MAX_STACKS),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .out_free  (out_free),
    .in_data   (s_axis_tdata),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule

### hw/rtl/qos_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Queue-of-stacks store checker
// Port-level properties of the store, bound to the top level.
// ----------------------------------------------------------------------------
module qos_checker import qos_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("Result beat dropped while stalled.");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("Result beat changed while stalled.");

  a_busy_after_beat: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("Input beat taken while a command is in progress.");

  a_one_kind: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(m_axis_tdata[OUT_ACC_BIT] && m_axis_tdata[OUT_VALID_BIT]))
    else $error("Result reports both a store and a ship.");

  a_flags: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(m_axis_tdata[OUT_EMPTY_BIT] && m_axis_tdata[OUT_FULL_BIT]))
    else $error("Result reports empty and full together.");

endmodule

bind queue_of_stacks_store_top qos_checker u_qos_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Queue-of-stacks store testbench
// Drives store and ship commands into the ring of stacks under several stack
// limits and idling patterns, predicts every result beat in a scoreboard that
// keeps its own copy of the ring, and compares each beat field by field.
// ----------------------------------------------------------------------------
module tb;
  import qos_pkg::*;

  localparam int RING_DEPTH      = 8;
  localparam int STACK_DEPTH     = 8;
  localparam int PHASES          = 11;
  localparam int ITEMS_PER_PHASE = 150;
  localparam int BURST_LEN       = 30;
  localparam int SETTLE_CYCLES   = 8;
  localparam int WATCHDOG_LIMIT  = 4000;

  typedef struct packed {
    logic               accepted;
    logic               shipped;
    logic [DEST_W-1:0]  dest;
    logic [VALUE_W-1:0] value;
    logic               empty;
    logic               full;
  } outcome_t;

  class stack_ring_checker;
    logic [PAYLOAD_W-1:0] slot_word [RING_DEPTH*STACK_DEPTH];
    int unsigned          fill [RING_DEPTH];
    int unsigned          oldest;
    int unsigned          open_stacks;
    logic [CFG_W-1:0]     stacks_reg;
    logic [CFG_W-1:0]     height_reg;
    outcome_t             awaited [$];
    int                   mismatches;

    function new();
      foreach (fill[i]) fill[i] = 0;
      oldest      = 0;
      open_stacks = 0;
      stacks_reg  = REG_RESET_VALUE;
      height_reg  = REG_RESET_VALUE;
      mismatches  = 0;
    endfunction

    function int unsigned clamp_limit(logic [CFG_W-1:0] r, int unsigned cap);
      if (r == 0) return 1;
      if (r > cap) return cap;
      return 32'(r);
    endfunction

    function int unsigned ring_at(int unsigned offset);
      return (oldest + offset) % RING_DEPTH;
    endfunction

    function void note_command(logic cmd, logic [DEST_W-1:0] dest,
                               logic [VALUE_W-1:0] value);
      int unsigned n;
      int unsigned h;
      int unsigned top;
      int unsigned s;
      logic        open_new;
      outcome_t    o;
      n = clamp_limit(stacks_reg, RING_DEPTH);
      h = clamp_limit(height_reg, STACK_DEPTH);
      o = '0;
      if (cmd == CMD_STORE) begin
        open_new = (open_stacks == 0) ||
                   (fill[ring_at(open_stacks - 1)] >= h && open_stacks < n);
        if (open_new) begin
          fill[ring_at(open_stacks)] = 0;
          open_stacks++;
        end
        top = ring_at(open_stacks - 1);
        if (fill[top] < h) begin
          slot_word[top*STACK_DEPTH + fill[top]] = {dest, value};
          fill[top]++;
          o.accepted = 1'b1;
        end
      end else if (open_stacks != 0) begin
        s = oldest;
        if (fill[s] != 0) begin
          fill[s]--;
          {o.dest, o.value} = slot_word[s*STACK_DEPTH + fill[s]];
          o.shipped = 1'b1;
        end
        if (fill[s] == 0) begin
          oldest = (oldest + 1) % RING_DEPTH;
          open_stacks--;
        end
      end
      o.empty = (open_stacks == 0);
      o.full  = (open_stacks != 0) && (open_stacks >= n) &&
                (fill[ring_at(open_stacks - 1)] >= h);
      awaited.push_back(o);
    endfunction

    function void report(string what, outcome_t want, outcome_t got);
      if (mismatches < 10) begin
        $display("%0t %s: expected acc=%b valid=%b dest=%h value=%h empty=%b full=%b",
                 $realtime, what, want.accepted, want.shipped, want.dest, want.value,
                 want.empty, want.full);
        $display("%0t %s:   actual acc=%b valid=%b dest=%h value=%h empty=%b full=%b",
                 $realtime, what, got.accepted, got.shipped, got.dest, got.value,
                 got.empty, got.full);
      end
      mismatches++;
    endfunction

    function void check_outcome(logic [OUT_DATA_W-1:0] beat);
      outcome_t got;
      outcome_t want;
      got.accepted = beat[OUT_ACC_BIT];
      got.shipped  = beat[OUT_VALID_BIT];
      got.dest     = beat[2 +: DEST_W];
      got.value    = beat[2 + DEST_W +: VALUE_W];
      got.empty    = beat[OUT_EMPTY_BIT];
      got.full     = beat[OUT_FULL_BIT];
      if (awaited.size() == 0) begin
        report("unexpected result beat", '0, got);
        return;
      end
      want = awaited.pop_front();
      if (got.accepted !== want.accepted || got.shipped !== want.shipped ||
          got.dest !== want.dest || got.value !== want.value ||
          got.empty !== want.empty || got.full !== want.full)
        report("result mismatch", want, got);
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [IN_USER_W-1:0]  s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_W-1:0]      cfg_data = '0;

  stack_ring_checker sb = new();
  int                send_idle_pct = 0;
  int                recv_stall_pct = 30;
  int                quiet_cycles = 0;

  logic [CFG_W-1:0] stack_setting  [PHASES] = '{4'd8, 4'd15, 4'd1, 4'd0, 4'd3, 4'd8,
                                                4'd1, 4'd2, 4'd9, 4'd5, 4'd4};
  logic [CFG_W-1:0] height_setting [PHASES] = '{4'd8, 4'd15, 4'd1, 4'd0, 4'd5, 4'd1,
                                                4'd8, 4'd2, 4'd12, 4'd3, 4'd7};

  queue_of_stacks_store_top #(
    .MAX_STACKS(RING_DEPTH),
    .MAX_HEIGHT(STACK_DEPTH)
  ) uut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Receiver back-pressure, result checking and the watchdog share one edge.
  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready)
        sb.check_outcome(m_axis_tdata);
      if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic send_item(input logic cmd, input logic [DEST_W-1:0] dest,
                           input logic [VALUE_W-1:0] value);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {value, dest};
    s_axis_tuser  <= cmd;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_command(cmd, dest, value);
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_limits(input logic [CFG_W-1:0] stacks,
                            input logic [CFG_W-1:0] height);
    cfg_we    <= 1'b1;
    cfg_index <= REG_NUM_STACKS;
    cfg_data  <= stacks;
    @(posedge clk);
    cfg_index <= REG_STACK_HEIGHT;
    cfg_data  <= height;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.stacks_reg = stacks;
    sb.height_reg = height;
  endtask

  initial begin
    int   store_pct;
    logic cmd;
    store_pct = 50;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset limits: a ship with nothing held, then a short push and pop.
    send_item(CMD_SHIP, 16'h0000, 32'h0000_0000);
    send_item(CMD_STORE, 16'hFFFF, 32'hFFFF_FFFF);
    send_item(CMD_STORE, 16'h0000, 32'h0000_0000);
    send_item(CMD_SHIP, 16'hFFFF, 32'hFFFF_FFFF);
    send_item(CMD_SHIP, 16'h0000, 32'h0000_0000);
    settle();

    // Two stacks of three: fill to full, reject one, then drain past empty.
    set_limits(4'd2, 4'd3);
    send_item(CMD_STORE, 16'hFFFF, 32'hFFFF_FFFF);
    send_item(CMD_STORE, 16'h0000, 32'h0000_0000);
    send_item(CMD_STORE, 16'h8001, 32'h8000_0001);
    for (int i = 0; i < 4; i++)
      send_item(CMD_STORE, 16'($urandom_range(16'hFFFF)), $urandom());
    for (int i = 0; i < 7; i++)
      send_item(CMD_SHIP, 16'($urandom_range(16'hFFFF)), $urandom());

    for (int p = 0; p < PHASES; p++) begin
      settle();
      set_limits(stack_setting[p], height_setting[p]);
      case (p % 4)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 55;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 55;
        end
        default: begin
          send_idle_pct = 30;
          recv_stall_pct = 30;
        end
      endcase
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        if (k % BURST_LEN == 0) begin
          case ($urandom_range(3))
            0: store_pct = 15;
            1: store_pct = 50;
            2: store_pct = 85;
            default: store_pct = 70;
          endcase
        end
        if (k == ITEMS_PER_PHASE / 2)
          settle();
        cmd = ($urandom_range(99) < store_pct) ? CMD_STORE : CMD_SHIP;
        send_item(cmd, 16'($urandom_range(16'hFFFF)), $urandom());
      end
    end

    settle();
    if (sb.awaited.size() == 0 && sb.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
